// File: hdl/mlprq_pkg.sv
// Shared widths, codes and defaults for the multi-level priority ready queue.
package mlprq_pkg;

    // Field widths of the command and result beats.
    localparam int OP_W       = 2;
    localparam int TASK_W     = 16;
    localparam int PRIO_W     = 8;
    localparam int LEVEL_W    = 5;
    localparam int SLICE_W    = 17;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int POLICY_W   = 2;

    // Parameter defaults.
    localparam int DEF_NUM_LEVELS  = 32;
    localparam int DEF_LEVEL_DEPTH = 256;
    localparam int DEF_MS_PER_TICK = 1;
    localparam int DEF_ID_WIDTH    = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_ID      = 2'd2;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] RST_BASE_QUANTUM = 16'd10;
    localparam logic [POLICY_W-1:0]   RST_POLICY_MODE  = 2'd1;
    localparam logic [CFG_DATA_W-1:0] RST_IDLE_ID      = 16'd0;

    // Per-level weighting of the slice in priority mode.
    localparam int SLICE_PER_LEVEL = 2;

endpackage

// File: hdl/mlprq_cmd_if.sv
// Command channel: one beat carries an operation, a task number and a priority.
interface mlprq_cmd_if import mlprq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [TASK_W-1:0]   task_number;
    logic [PRIO_W-1:0]   task_priority;

    modport source(output valid, operation, task_number, task_priority, input ready);
    modport sink(input valid, operation, task_number, task_priority, output ready);
endinterface

// File: hdl/mlprq_res_if.sv
// Result channel: one beat carries a task, a level, a slice and a status.
interface mlprq_res_if import mlprq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TASK_W-1:0]   result_task;
    logic [LEVEL_W-1:0]  result_level;
    logic [SLICE_W-1:0]  slice_ticks;
    logic [STATUS_W-1:0] status;

    modport source(output valid, result_task, result_level, slice_ticks, status, input ready);
    modport sink(input valid, result_task, result_level, slice_ticks, status, output ready);
endinterface

// File: hdl/mlprq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mlprq_ram import mlprq_pkg::*; #(
    parameter int WIDTH = DEF_ID_WIDTH,
    parameter int DEPTH = DEF_NUM_LEVELS * DEF_LEVEL_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/multi_level_priority_ready_queue_top.sv
// Top level of the multi-level priority ready queue.
//
// Commands arrive on i_cmd (enqueue, dequeue, remove by number) and each one
// gives exactly one beat on o_res. Configuration is written through i_cfg_we,
// i_cfg_idx and i_cfg_data; a write lands in its register and holds off the
// next command through r_cfg_hold; the base slice is then recomputed.
// The task numbers of all levels live in one RAM with a registered read
// port; head, tail and count of each level sit in flip-flops.
// A remove visits the levels in turn from level 0, compares the entries of
// each non-empty level from its head and shifts the entries behind a match.
// The single RAM port pair and the control sequencer handle one command at a
// time, so a new command is taken only after the last one has finished.
// After reset all levels are empty, the registers hold their defaults and a
// command can be taken in the next cycle; no RAM clearing pass is needed.
// A finished result sits in the output register; if the receiver stalls a
// second result waits in a holding register and no new command is taken.
module multi_level_priority_ready_queue_top import mlprq_pkg::*; #(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int MS_PER_TICK = DEF_MS_PER_TICK,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mlprq_cmd_if.sink             i_cmd,
    mlprq_res_if.source           o_res
);

    localparam int LW    = $clog2(NUM_LEVELS);
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (ID_WIDTH < TASK_W) ? ID_WIDTH : TASK_W;
    localparam logic [31:0] RECIP = 32'hFFFF_FFFF / MS_PER_TICK;
    localparam logic [TASK_W-1:0] RST_SLICE = TASK_W'(RST_BASE_QUANTUM / MS_PER_TICK);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ENQ      = 3'd1;
    localparam logic [2:0] S_DEQ      = 3'd2;
    localparam logic [2:0] S_RM_LVL   = 3'd3;
    localparam logic [2:0] S_RM_CMP   = 3'd4;
    localparam logic [2:0] S_RM_SHIFT = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(LEVEL_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lv,
                                                 input logic [PW-1:0] p);
        return AW'(lv) * AW'(LEVEL_DEPTH) + AW'(p);
    endfunction

    function automatic logic [LEVEL_W-1:0] lvl_out(input logic [LW-1:0] lv);
        logic [6:0] w;
        w = 7'(lv);
        return w[LEVEL_W-1:0];
    endfunction

    function automatic logic [SLICE_W-1:0] slice_of(input logic [TASK_W-1:0]   base,
                                                    input logic [POLICY_W-1:0] pol,
                                                    input logic [LW-1:0]       lv);
        logic [SLICE_W-1:0] s;
        s = SLICE_W'(base);
        if (pol != '0) begin
            s = s + (SLICE_W'(NUM_LEVELS - 1) - SLICE_W'(lv)) * SLICE_W'(SLICE_PER_LEVEL);
        end
        return s;
    endfunction

    // Configuration registers and base slice pipeline.
    logic [CFG_DATA_W-1:0] r_base_quantum;
    logic [POLICY_W-1:0]   r_policy;
    logic [CFG_DATA_W-1:0] r_idle_id;
    logic                  r_cfg_hold;
    logic [TASK_W-1:0]     r_qest;
    logic [TASK_W-1:0]     r_base_d1;
    logic [TASK_W-1:0]     r_base_slice;
    logic [47:0]           qest_prod;
    logic [23:0]           back_prod;
    logic [23:0]           qest_rem;

    // Control and level state.
    logic [2:0]          r_state, n_state;
    logic [SW-1:0]       r_task, n_task;
    logic [LW-1:0]       r_lv, n_lv;
    logic                r_empty, n_empty;
    logic [PW-1:0]       r_p, n_p;
    logic [CW-1:0]       r_i, n_i;
    logic [PW-1:0]       r_head [NUM_LEVELS];
    logic [PW-1:0]       r_tail [NUM_LEVELS];
    logic [CW-1:0]       r_cnt  [NUM_LEVELS];

    // Result holding and output registers.
    logic [TASK_W-1:0]   r_pend_task, n_pend_task;
    logic [LEVEL_W-1:0]  r_pend_level, n_pend_level;
    logic [SLICE_W-1:0]  r_pend_slice, n_pend_slice;
    logic [STATUS_W-1:0] r_pend_status, n_pend_status;
    logic                r_out_valid, n_out_valid;
    logic [TASK_W-1:0]   r_out_task, n_out_task;
    logic [LEVEL_W-1:0]  r_out_level, n_out_level;
    logic [SLICE_W-1:0]  r_out_slice, n_out_slice;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic [NUM_LEVELS-1:0] nonempty;
    logic [LW-1:0]         prienc;
    logic [LW-1:0]         lvl_idx;
    logic [PW-1:0]         cur_head, cur_tail;
    logic [CW-1:0]         cur_cnt;
    logic                  lvl_we;
    logic [PW-1:0]         w_head, w_tail;
    logic [CW-1:0]         w_cnt;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [SW-1:0]         mem_wdata, mem_rdata;
    logic                  cmd_acc, slot_free;
    logic                  fin_valid;
    logic [TASK_W-1:0]     fin_task;
    logic [LEVEL_W-1:0]    fin_level;
    logic [SLICE_W-1:0]    fin_slice;
    logic [STATUS_W-1:0]   fin_status;
    logic [LW-1:0]         clamp_lv;

    // Register writes; each holds off commands through r_cfg_hold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_quantum <= RST_BASE_QUANTUM;
            r_policy       <= RST_POLICY_MODE;
            r_idle_id      <= RST_IDLE_ID;
            r_cfg_hold     <= 1'b0;
        end else begin
            r_cfg_hold <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_QUANTUM: r_base_quantum <= i_cfg_data;
                    REG_POLICY_MODE:  r_policy       <= i_cfg_data[POLICY_W-1:0];
                    REG_IDLE_ID:      r_idle_id      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Base slice: reciprocal multiply, then one correction step.
    assign qest_prod = 48'(r_base_quantum) * 48'(RECIP);
    assign back_prod = 24'(r_qest) * 24'(MS_PER_TICK);
    assign qest_rem  = 24'(r_base_d1) - back_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qest       <= RST_SLICE;
            r_base_d1    <= RST_BASE_QUANTUM;
            r_base_slice <= RST_SLICE;
        end else begin
            r_qest       <= qest_prod[47:32];
            r_base_d1    <= r_base_quantum;
            r_base_slice <= (qest_rem >= 24'(MS_PER_TICK)) ? r_qest + 1'b1 : r_qest;
        end
    end

    // Occupancy flags and the highest-priority non-empty level.
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            nonempty[l] = (r_cnt[l] != '0);
        end
    end

    always_comb begin
        prienc = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (nonempty[l]) begin
                prienc = LW'(l);
            end
        end
    end

    // One level is looked at per cycle.
    assign lvl_idx  = (r_state == S_IDLE) ? prienc : r_lv;
    assign cur_head = r_head[lvl_idx];
    assign cur_tail = r_tail[lvl_idx];
    assign cur_cnt  = r_cnt[lvl_idx];

    assign clamp_lv = (i_cmd.task_priority >= PRIO_W'(NUM_LEVELS)) ?
                      LW'(NUM_LEVELS - 1) : LW'(i_cmd.task_priority);

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign slot_free   = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && !r_cfg_hold;

    // Sequencer.
    always_comb begin
        logic [CW:0] i_nx;
        logic [CW:0] i_nx2;
        logic [CW:0] n_ext;
        i_nx  = (CW+1)'(r_i) + 1'b1;
        i_nx2 = (CW+1)'(r_i) + 2'd2;
        n_ext = (CW+1)'(cur_cnt);

        n_state = r_state;
        n_task  = r_task;
        n_lv    = r_lv;
        n_empty = r_empty;
        n_p     = r_p;
        n_i     = r_i;
        lvl_we  = 1'b0;
        w_head  = cur_head;
        w_tail  = cur_tail;
        w_cnt   = cur_cnt;
        mem_we    = 1'b0;
        mem_waddr = slot_addr(r_lv, r_p);
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = slot_addr(r_lv, ptr_inc(r_p));
        fin_valid  = 1'b0;
        fin_task   = 16'(r_task);
        fin_level  = '0;
        fin_slice  = '0;
        fin_status = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_task = i_cmd.task_number[SW-1:0];
                    case (i_cmd.operation)
                        OP_ENQUEUE: begin
                            n_lv    = clamp_lv;
                            n_state = S_ENQ;
                        end
                        OP_DEQUEUE: begin
                            n_lv    = prienc;
                            n_empty = ~|nonempty;
                            n_state = S_DEQ;
                            if (|nonempty) begin
                                mem_re    = 1'b1;
                                mem_raddr = slot_addr(prienc, cur_head);
                                lvl_we    = 1'b1;
                                w_head    = ptr_inc(cur_head);
                                w_cnt     = cur_cnt - 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            n_lv    = '0;
                            n_state = S_RM_LVL;
                        end
                        default: begin
                            fin_valid  = 1'b1;
                            fin_task   = 16'(i_cmd.task_number[SW-1:0]);
                            fin_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_ENQ: begin
                fin_valid = 1'b1;
                fin_level = lvl_out(r_lv);
                if (cur_cnt == CW'(LEVEL_DEPTH)) begin
                    fin_status = ST_FULL;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_addr(r_lv, cur_tail);
                    mem_wdata = r_task;
                    lvl_we    = 1'b1;
                    w_tail    = ptr_inc(cur_tail);
                    w_cnt     = cur_cnt + 1'b1;
                end
            end

            S_DEQ: begin
                fin_valid = 1'b1;
                if (!r_empty) begin
                    fin_task  = 16'(mem_rdata);
                    fin_level = lvl_out(r_lv);
                    fin_slice = slice_of(r_base_slice, r_policy, r_lv);
                end else if (r_idle_id != '0) begin
                    fin_task   = 16'(r_idle_id[SW-1:0]);
                    fin_level  = lvl_out(LW'(NUM_LEVELS - 1));
                    fin_slice  = slice_of(r_base_slice, r_policy, LW'(NUM_LEVELS - 1));
                    fin_status = ST_IDLE;
                end else begin
                    fin_task   = '0;
                    fin_status = ST_NONE;
                end
            end

            S_RM_LVL: begin
                if (cur_cnt == '0) begin
                    if (r_lv == LW'(NUM_LEVELS - 1)) begin
                        fin_valid  = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end else begin
                        n_lv = r_lv + 1'b1;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_addr(r_lv, cur_head);
                    n_p       = cur_head;
                    n_i       = '0;
                    n_state   = S_RM_CMP;
                end
            end

            S_RM_CMP: begin
                if (mem_rdata == r_task) begin
                    if (i_nx < n_ext) begin
                        // Entries behind the match move up one place.
                        mem_re  = 1'b1;
                        n_state = S_RM_SHIFT;
                    end else begin
                        fin_valid = 1'b1;
                        fin_level = lvl_out(r_lv);
                        lvl_we    = 1'b1;
                        w_tail    = ptr_dec(cur_tail);
                        w_cnt     = cur_cnt - 1'b1;
                    end
                end else if (i_nx < n_ext) begin
                    mem_re = 1'b1;
                    n_p    = ptr_inc(r_p);
                    n_i    = i_nx[CW-1:0];
                end else if (r_lv == LW'(NUM_LEVELS - 1)) begin
                    fin_valid  = 1'b1;
                    fin_status = ST_NOT_FOUND;
                end else begin
                    n_lv    = r_lv + 1'b1;
                    n_state = S_RM_LVL;
                end
            end

            S_RM_SHIFT: begin
                mem_we = 1'b1;
                if (i_nx2 < n_ext) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_addr(r_lv, ptr_inc(ptr_inc(r_p)));
                    n_p       = ptr_inc(r_p);
                    n_i       = i_nx[CW-1:0];
                end else begin
                    fin_valid = 1'b1;
                    fin_level = lvl_out(r_lv);
                    lvl_we    = 1'b1;
                    w_tail    = ptr_dec(cur_tail);
                    w_cnt     = cur_cnt - 1'b1;
                end
            end

            S_EMIT: begin
                fin_valid  = 1'b1;
                fin_task   = r_pend_task;
                fin_level  = r_pend_level;
                fin_slice  = r_pend_slice;
                fin_status = r_pend_status;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes to the output register or waits.
        n_pend_task   = r_pend_task;
        n_pend_level  = r_pend_level;
        n_pend_slice  = r_pend_slice;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_task    = r_out_task;
        n_out_level   = r_out_level;
        n_out_slice   = r_out_slice;
        n_out_status  = r_out_status;
        if (fin_valid) begin
            if (slot_free) begin
                n_out_valid  = 1'b1;
                n_out_task   = fin_task;
                n_out_level  = fin_level;
                n_out_slice  = fin_slice;
                n_out_status = fin_status;
                n_state      = S_IDLE;
            end else begin
                n_pend_task   = fin_task;
                n_pend_level  = fin_level;
                n_pend_slice  = fin_slice;
                n_pend_status = fin_status;
                n_state       = S_EMIT;
            end
        end
    end

    // Control registers and per-level pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (lvl_we) begin
                r_head[lvl_idx] <= w_head;
                r_tail[lvl_idx] <= w_tail;
                r_cnt[lvl_idx]  <= w_cnt;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_task        <= n_task;
        r_lv          <= n_lv;
        r_empty       <= n_empty;
        r_p           <= n_p;
        r_i           <= n_i;
        r_pend_task   <= n_pend_task;
        r_pend_level  <= n_pend_level;
        r_pend_slice  <= n_pend_slice;
        r_pend_status <= n_pend_status;
        r_out_task    <= n_out_task;
        r_out_level   <= n_out_level;
        r_out_slice   <= n_out_slice;
        r_out_status  <= n_out_status;
    end

    // Task store for all levels.
    mlprq_ram #(
        .WIDTH(SW),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_res.valid        = r_out_valid;
    assign o_res.result_task  = r_out_task;
    assign o_res.result_level = r_out_level;
    assign o_res.slice_ticks  = r_out_slice;
    assign o_res.status       = r_out_status;

    // A level never holds more entries than its ring.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[lvl_idx] <= CW'(LEVEL_DEPTH))
        else $error("level count exceeds ring depth");

    // A register write holds off the next command.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_cmd.ready)
        else $error("command taken while base slice is being updated");

    // A known command keeps the sequencer busy after it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && (i_cmd.operation == OP_ENQUEUE || i_cmd.operation == OP_DEQUEUE ||
                    i_cmd.operation == OP_REMOVE) |=> !i_cmd.ready)
        else $error("new command taken while one is in work");

    // A dropped enqueue never carries a slice.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_FULL) |-> r_out_slice == '0)
        else $error("full status with non-zero slice");

endmodule
